@@ sv/clt_pkg.sv @@
// Package for the command line tokenizer: parse mode codes, result kinds,
// character constants, count widths and the shared result and state types.
// No dependencies.
`default_nettype none

package clt_pkg;

  localparam int MAX_TOKENS = 1024;
  localparam int CNT_W = $clog2(MAX_TOKENS + 1);
  localparam int WIDE_W = CNT_W + 12;
  localparam int RES_N = 3;

  localparam logic [2:0] MODE_BETWEEN = 3'd0;
  localparam logic [2:0] MODE_TOKEN = 3'd1;
  localparam logic [2:0] MODE_QUOTED = 3'd2;
  localparam logic [2:0] MODE_COMMENT = 3'd3;
  localparam logic [2:0] MODE_STOPPED = 3'd4;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic CFG_IGNORE_QUOTES = 1'b0;
  localparam logic CFG_TOKEN_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [9:0] token_index;
    logic [10:0] token_count;
    logic last;
  } res_t;

  typedef struct packed {
    logic [2:0] mode;
    logic slash_pending;
    logic star_seen;
    logic [CNT_W-1:0] tokens;
  } parse_st_t;

  typedef struct packed {
    logic [1:0] n;
    res_t [RES_N-1:0] res;
  } res_grp_t;

  function automatic res_t make_res(logic [1:0] kind, logic [7:0] data,
                                    logic [CNT_W-1:0] tokens);
    res_t r;
    logic [WIDE_W-1:0] cnt;
    logic [WIDE_W-1:0] idx;
    cnt = WIDE_W'(tokens);
    idx = (kind == KIND_DONE || cnt == '0) ? '0 : cnt - WIDE_W'(1);
    r.kind = kind;
    r.data = data;
    r.token_index = idx[9:0];
    r.token_count = cnt[10:0];
    r.last = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/clt_step.sv @@
// Combinational parse step of the tokenizer: one text byte and the parser
// state give the next state and up to three result words. Uses clt_pkg.
`default_nettype none

module clt_step (
  input  wire logic [7:0]               ch,
  input  wire logic                     ignore_quotes,
  input  wire logic [clt_pkg::WIDE_W-1:0] limit,
  input  wire clt_pkg::parse_st_t       st_in,
  output clt_pkg::parse_st_t            st_out,
  output clt_pkg::res_grp_t             grp
);

  always_comb begin
    clt_pkg::parse_st_t s;
    logic [1:0] n;
    logic consumed;
    logic skip;
    logic sep;
    logic quote;
    s = st_in;
    n = 2'd0;
    consumed = 1'b0;
    skip = 1'b0;
    grp.res = '0;
    sep = (ch <= clt_pkg::CH_SPACE) || ch[7];
    quote = !ignore_quotes && ch == clt_pkg::CH_QUOTE;

    if (s.slash_pending &&
        (s.mode == clt_pkg::MODE_BETWEEN || s.mode == clt_pkg::MODE_TOKEN)) begin
      if (ch == clt_pkg::CH_SLASH || ch == clt_pkg::CH_STAR) begin
        if (s.mode == clt_pkg::MODE_TOKEN) begin
          grp.res[n] = clt_pkg::make_res(clt_pkg::KIND_END, 8'd0, s.tokens);
          n = n + 2'd1;
        end
        if (ch == clt_pkg::CH_SLASH) begin
          s.mode = clt_pkg::MODE_STOPPED;
        end else begin
          s.mode = clt_pkg::MODE_COMMENT;
          s.star_seen = 1'b1;
        end
        consumed = 1'b1;
      end else if (s.mode == clt_pkg::MODE_TOKEN) begin
        grp.res[n] = clt_pkg::make_res(clt_pkg::KIND_BYTE, clt_pkg::CH_SLASH, s.tokens);
        n = n + 2'd1;
      end else if (clt_pkg::WIDE_W'(s.tokens) >= limit) begin
        s.mode = clt_pkg::MODE_STOPPED;
      end else begin
        s.tokens = s.tokens + clt_pkg::CNT_W'(1);
        s.mode = clt_pkg::MODE_TOKEN;
        grp.res[n] = clt_pkg::make_res(clt_pkg::KIND_BYTE, clt_pkg::CH_SLASH, s.tokens);
        n = n + 2'd1;
      end
    end
    s.slash_pending = 1'b0;

    if (!consumed) begin
      if (ch == 8'd0) begin
        if (s.mode == clt_pkg::MODE_TOKEN || s.mode == clt_pkg::MODE_QUOTED) begin
          grp.res[n] = clt_pkg::make_res(clt_pkg::KIND_END, 8'd0, s.tokens);
          n = n + 2'd1;
        end
        grp.res[n] = clt_pkg::make_res(clt_pkg::KIND_DONE, 8'd0, s.tokens);
        n = n + 2'd1;
        s.mode = clt_pkg::MODE_BETWEEN;
        s.star_seen = 1'b0;
        s.tokens = '0;
      end else begin
        case (s.mode)
          clt_pkg::MODE_BETWEEN, clt_pkg::MODE_TOKEN: begin
            if (s.mode == clt_pkg::MODE_TOKEN) begin
              if (sep || quote) begin
                grp.res[n] = clt_pkg::make_res(clt_pkg::KIND_END, 8'd0, s.tokens);
                n = n + 2'd1;
                s.mode = clt_pkg::MODE_BETWEEN;
              end else if (ch == clt_pkg::CH_SLASH) begin
                s.slash_pending = 1'b1;
                skip = 1'b1;
              end else begin
                grp.res[n] = clt_pkg::make_res(clt_pkg::KIND_BYTE, ch, s.tokens);
                n = n + 2'd1;
                skip = 1'b1;
              end
            end
            if (!skip && !sep) begin
              if (ch == clt_pkg::CH_SLASH && !quote) begin
                s.slash_pending = 1'b1;
              end else if (clt_pkg::WIDE_W'(s.tokens) >= limit) begin
                s.mode = clt_pkg::MODE_STOPPED;
              end else begin
                s.tokens = s.tokens + clt_pkg::CNT_W'(1);
                if (quote) begin
                  s.mode = clt_pkg::MODE_QUOTED;
                end else begin
                  s.mode = clt_pkg::MODE_TOKEN;
                  grp.res[n] = clt_pkg::make_res(clt_pkg::KIND_BYTE, ch, s.tokens);
                  n = n + 2'd1;
                end
              end
            end
          end
          clt_pkg::MODE_QUOTED: begin
            if (ch == clt_pkg::CH_QUOTE) begin
              grp.res[n] = clt_pkg::make_res(clt_pkg::KIND_END, 8'd0, s.tokens);
              n = n + 2'd1;
              s.mode = clt_pkg::MODE_BETWEEN;
            end else begin
              grp.res[n] = clt_pkg::make_res(clt_pkg::KIND_BYTE, ch, s.tokens);
              n = n + 2'd1;
            end
          end
          clt_pkg::MODE_COMMENT: begin
            if (s.star_seen && ch == clt_pkg::CH_SLASH) begin
              s.star_seen = 1'b0;
              s.mode = clt_pkg::MODE_BETWEEN;
            end else begin
              s.star_seen = (ch == clt_pkg::CH_STAR);
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (n != 2'd0) begin
      grp.res[n - 2'd1].last = 1'b1;
    end
    grp.n = n;
    st_out = s;
  end

endmodule

`default_nettype wire

@@ sv/command_line_tokenizer_core.sv @@
// Top level of the command line tokenizer: configuration registers, parser
// state and a four-deep queue of result groups. Depends on clt_pkg and clt_step.
// The first word of a byte is offered in the cycle after the byte is accepted
// when the queue is empty; the other words of the byte follow one per cycle while out_stall is low.
// Throughput: one byte per cycle until the queue holds four groups, then in_stall rises.
// Reset clears the parser and the queue, sets token_limit to 1024 and honors quotes.
`default_nettype none

module command_line_tokenizer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_ch,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data,
  output logic [9:0]       out_token_index,
  output logic [10:0]      out_token_count,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data
);

  localparam int QD = 4;
  localparam int QA = $clog2(QD);

  logic ignore_quotes_r;
  logic [10:0] token_limit_r;
  clt_pkg::parse_st_t st_r;
  clt_pkg::parse_st_t st_nxt;
  clt_pkg::res_grp_t grp;
  clt_pkg::res_grp_t q_r [QD];
  logic [QA-1:0] wr_ptr_r;
  logic [QA-1:0] rd_ptr_r;
  logic [QA:0] count_r;
  logic [1:0] sub_r;
  logic [clt_pkg::WIDE_W-1:0] limit;
  logic in_acc;
  logic push;
  logic pop;
  logic grp_done;
  clt_pkg::res_t cur;

  assign limit = (clt_pkg::WIDE_W'(token_limit_r) > clt_pkg::WIDE_W'(clt_pkg::MAX_TOKENS)) ?
                 clt_pkg::WIDE_W'(clt_pkg::MAX_TOKENS) : clt_pkg::WIDE_W'(token_limit_r);

  clt_step u_step (
    .ch(in_ch),
    .ignore_quotes(ignore_quotes_r),
    .limit(limit),
    .st_in(st_r),
    .st_out(st_nxt),
    .grp(grp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall = (count_r == (QA+1)'(QD));
  assign in_acc = in_valid && !in_stall;
  assign push = in_acc && grp.n != 2'd0;
  assign out_valid = count_r != '0;
  assign cur = q_r[rd_ptr_r].res[sub_r];
  assign pop = out_valid && !out_stall;
  assign grp_done = sub_r == q_r[rd_ptr_r].n - 2'd1;

  assign out_kind = cur.kind;
  assign out_data = cur.data;
  assign out_token_index = cur.token_index;
  assign out_token_count = cur.token_count;
  assign out_last = cur.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_quotes_r <= 1'b0;
      token_limit_r <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clt_pkg::CFG_IGNORE_QUOTES: ignore_quotes_r <= cfg_data[0];
        clt_pkg::CFG_TOKEN_LIMIT: token_limit_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode <= clt_pkg::MODE_BETWEEN;
      st_r.slash_pending <= 1'b0;
      st_r.star_seen <= 1'b0;
      st_r.tokens <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
      sub_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QA'(1);
      end
      if (pop) begin
        if (grp_done) begin
          sub_r <= 2'd0;
          rd_ptr_r <= rd_ptr_r + QA'(1);
        end else begin
          sub_r <= sub_r + 2'd1;
        end
      end
      if (push && !(pop && grp_done)) begin
        count_r <= count_r + (QA+1)'(1);
      end else if (!push && pop && grp_done) begin
        count_r <= count_r - (QA+1)'(1);
      end
    end
  end

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == clt_pkg::KIND_DONE |-> out_last)
    else $error("done word is not the last word of its byte");

  a_done_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == clt_pkg::KIND_DONE |-> out_token_index == 10'd0)
    else $error("done word carries a token index");

  a_last_ends_group: assert property (@(posedge clk) disable iff (!rst_n)
    pop && out_last |=> sub_r == 2'd0)
    else $error("group sequencing did not restart after the last word");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QA+1)'(QD))
    else $error("result queue overflow");

endmodule

`default_nettype wire
